/* rtl/nss_pkg.sv */
// Shared constants, payload structs and the cell link type for the NFA matcher.
// Used by nss_cell and nfa_subset_step_matcher; depends on nothing.
package nss_pkg;

  // Automaton size.
  localparam int STATES  = 32;
  localparam int SYMBOLS = 16;
  localparam int SYM_W   = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

  // Input command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Configuration register indexes (byte address bit 2).
  localparam logic REG_INITIAL = 1'b0;
  localparam logic REG_FINAL   = 1'b1;

  // Register reset values.
  localparam logic [31:0] INITIAL_RESET = 32'd1;
  localparam logic [31:0] FINAL_RESET   = 32'd0;

  typedef struct packed {
    logic        cmd;
    logic [4:0]  from_state;
    logic [3:0]  symbol;
    logic [31:0] next_states;
    logic        last_symbol;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] active_states;
  } out_item_t;

  // Partial union that travels down the row of cells, one cell per cycle.
  typedef struct packed {
    logic              vld;
    logic [SYM_W-1:0]  sym;
    logic [STATES-1:0] acc;
  } nss_link_t;

endpackage

/* rtl/nss_cell.sv */
// One per-state cell: the state's transition rows for every symbol and one link stage.
// Depends on nss_pkg for sizes and the link struct.
module nss_cell
  import nss_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [SYM_W-1:0]  wr_sym_i,
  input  logic [STATES-1:0] wr_row_i,
  input  logic              act_i,
  input  nss_link_t         link_i,
  output nss_link_t         link_o
);

  logic [STATES-1:0] rows_q [SYMBOLS];
  nss_link_t         link_d;
  nss_link_t         link_q;

  // Transition rows; reset means no transitions.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SYMBOLS; s++) begin
        rows_q[s] <= '0;
      end
    end else if (wr_en_i) begin
      rows_q[wr_sym_i] <= wr_row_i;
    end
  end

  // Add this state's row to the passing union when the state is active.
  always_comb begin
    link_d     = link_i;
    if (act_i) begin
      link_d.acc = link_i.acc | rows_q[link_i.sym];
    end
  end

  // Link stage towards the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= '0;
    end else begin
      link_q <= link_d;
    end
  end

  assign link_o = link_q;

endmodule

/* rtl/nfa_subset_step_matcher.sv */
// NFA subset-step matcher: a table write loads one transition row; a symbol step registers
// its start, then the union ripples through the row of STATES cells, one cell per cycle.
// A last symbol then marks a result pending and loads it once the output is free.
// Reset is asynchronous and active low; it clears the transition table, loads
// initial_states = 1 and final_states = 0, and sets the active set to the initial mask.
module nfa_subset_step_matcher
  import nss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0]       initial_q;
  logic [31:0]       final_q;
  logic [STATES-1:0] active_q;
  logic              busy_q;
  logic              start_q;
  logic              pend_q;
  logic              last_q;
  logic              sym_ok_q;
  logic [SYM_W-1:0]  sym_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic              in_acc;
  logic              step_acc;
  logic              wr_acc;
  logic              in_sym_ok;
  logic              done;
  logic [STATES-1:0] next_act;
  logic [STATES-1:0] wr_en;
  logic [STATES:0]   vld_vec;
  nss_link_t         chain [STATES+1];

  // Register port: always ready, write on the access cycle.
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      REG_INITIAL: prdata = initial_q;
      REG_FINAL:   prdata = final_q;
      default:     prdata = initial_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initial_q <= INITIAL_RESET;
      final_q   <= FINAL_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_INITIAL: initial_q <= pwdata;
        REG_FINAL:   final_q   <= pwdata;
        default:     initial_q <= pwdata;
      endcase
    end
  end

  // Input transaction decode.
  assign in_ready_o = !busy_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign step_acc   = in_acc && (in_data_i.cmd == CMD_STEP);
  assign wr_acc     = in_acc && (in_data_i.cmd == CMD_WRITE);
  assign in_sym_ok  = int'(in_data_i.symbol) < SYMBOLS;

  // Row write enables, one per source state.
  always_comb begin
    for (int i = 0; i < STATES; i++) begin
      wr_en[i] = wr_acc && in_sym_ok && (int'(in_data_i.from_state) == i);
    end
  end

  // Row of cells; the head injects an empty union for the current symbol.
  assign chain[0].vld = start_q;
  assign chain[0].sym = sym_q;
  assign chain[0].acc = '0;

  for (genvar g = 0; g < STATES; g++) begin : g_cell
    nss_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_en_i  (wr_en[g]),
      .wr_sym_i (SYM_W'(in_data_i.symbol)),
      .wr_row_i (STATES'(in_data_i.next_states)),
      .act_i    (active_q[g]),
      .link_i   (chain[g]),
      .link_o   (chain[g+1])
    );
  end

  assign done     = chain[STATES].vld;
  assign next_act = sym_ok_q ? chain[STATES].acc : '0;

  // Step sequencing, active set and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      active_q    <= STATES'(INITIAL_RESET);
    end else begin
      start_q <= step_acc;
      if (step_acc) begin
        busy_q <= 1'b1;
      end
      if (done) begin
        active_q <= next_act;
        if (last_q) begin
          pend_q <= 1'b1;
        end else begin
          busy_q <= 1'b0;
        end
      end
      if (pend_q && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
        busy_q      <= 1'b0;
        active_q    <= STATES'(initial_q);
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (step_acc) begin
      sym_q    <= SYM_W'(in_data_i.symbol);
      sym_ok_q <= in_sym_ok;
      last_q   <= in_data_i.last_symbol;
    end
    if (pend_q && (!out_valid_q || out_ready_i)) begin
      out_q.accepted      <= |(32'(active_q) & final_q);
      out_q.active_states <= 32'(active_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Valid bits along the row, for checking.
  always_comb begin
    for (int i = 0; i <= STATES; i++) begin
      vld_vec[i] = chain[i].vld;
    end
  end

`ifndef NO_ASSERTIONS
  // At most one symbol travels the row of cells at a time.
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(vld_vec))
    else $error("more than one step in flight");

  // A step reaching the end of the row belongs to a busy block with no pending result.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> (busy_q && !pend_q))
    else $error("step finished while idle or with a pending result");

  // A pending result keeps input transactions blocked.
  a_pend_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !in_ready_o)
    else $error("input accepted while a result is pending");

  // A new result appears only after a pending one.
  a_out_from_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pend_q))
    else $error("result without a finished word");
`endif

endmodule
